// ===== rtl/event_flag_group_wait_wake_core_defines.svh =====
// Assertion macros used by the checker file
`ifndef EVENT_FLAG_GROUP_WAIT_WAKE_CORE_DEFINES_SVH
`define EVENT_FLAG_GROUP_WAIT_WAKE_CORE_DEFINES_SVH

// implication checked on every clock, quiet during reset
`define EFG_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define EFG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/efg_pkg.sv =====
package efg_pkg;

  localparam int WaitDepth = 16;
  localparam int TaskIdBits = 5;
  localparam int PrioBits = 8;
  localparam int IdxBits = $clog2(WaitDepth);
  localparam int CntBits = $clog2(WaitDepth + 1);

  typedef logic [2:0] status_t;
  localparam status_t ST_POST_IDLE   = 3'd0;
  localparam status_t ST_POST_WOKE   = 3'd1;
  localparam status_t ST_PEND_GRANT  = 3'd2;
  localparam status_t ST_PEND_QUEUED = 3'd3;
  localparam status_t ST_PEND_FULL   = 3'd4;

  localparam logic REQ_POST = 1'b0;
  localparam logic REQ_PEND = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_SCAN,
    S_WAKE,
    S_SHIFT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic apply;
    logic scan_step;
    logic wake;
    logic shift_step;
    logic done;
  } efg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pend;
    logic scan_last;
    logic found;
    logic shift_last;
  } efg_stat_t;

  function automatic logic flags_match(input logic [31:0] flags, input logic [31:0] mask,
                                       input logic [1:0] mode);
    logic [31:0] hit;
    hit = flags & mask;
    case (mode)
      2'd0: return hit == mask;
      2'd1: return hit != '0;
      2'd2: return hit == '0;
      default: return hit != mask;
    endcase
  endfunction

endpackage

// ===== rtl/event_flag_group_wait_wake_core.sv =====
// Event flag group with a 16-entry wait table. Pulse start while busy is low
// to issue a request; exactly one result follows, shown for one cycle with
// done high, and it cannot be held off. A pend passes through the apply and
// done states. A post also scans every occupied table entry in order (at
// least one), and on a wake removes the winner and moves each later entry
// down one place; the busy time is set by the one-entry-per-cycle table access.
// The result is registered from the done state, and a new request may start
// in the cycle that shows the result.
// cfg_valid loads the flag word and empties the table; write it only while
// busy is low.
module event_flag_group_wait_wake_core
  import efg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [31:0]           bit_mask,
  input  logic [1:0]            option,
  input  logic [TaskIdBits-1:0] task_id,
  input  logic [PrioBits-1:0]   task_priority,
  output logic                  done,
  output logic [2:0]            status,
  output logic [TaskIdBits-1:0] woken_task,
  output logic [31:0]           flags_after
);

  efg_cmd_t  cmd;
  efg_stat_t stat;

  assign cfg_ready = 1'b1;

  efg_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  efg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .bit_mask     (bit_mask),
    .option       (option),
    .task_id      (task_id),
    .task_priority(task_priority),
    .done         (done),
    .status       (status),
    .woken_task   (woken_task),
    .flags_after  (flags_after)
  );

endmodule

// ===== rtl/efg_ctrl.sv =====
module efg_ctrl
  import efg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  efg_stat_t stat,
  output efg_cmd_t  cmd,
  output logic      busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_APPLY;
      S_APPLY: state_next = stat.is_pend ? S_DONE : S_SCAN;
      S_SCAN:  if (stat.scan_last) state_next = stat.found ? S_WAKE : S_DONE;
      S_WAKE:  state_next = stat.shift_last ? S_DONE : S_SHIFT;
      S_SHIFT: if (stat.shift_last) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE:  cmd.load_req = start;
      S_APPLY: cmd.apply = 1'b1;
      S_SCAN:  cmd.scan_step = 1'b1;
      S_WAKE:  cmd.wake = 1'b1;
      S_SHIFT: cmd.shift_step = 1'b1;
      S_DONE:  cmd.done = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/efg_dp.sv =====
module efg_dp
  import efg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  efg_cmd_t              cmd,
  output efg_stat_t             stat,
  input  logic                  cfg_valid,
  input  logic [31:0]           cfg_data,
  input  logic                  req_type,
  input  logic [31:0]           bit_mask,
  input  logic [1:0]            option,
  input  logic [TaskIdBits-1:0] task_id,
  input  logic [PrioBits-1:0]   task_priority,
  output logic                  done,
  output status_t               status,
  output logic [TaskIdBits-1:0] woken_task,
  output logic [31:0]           flags_after
);

  logic [31:0] flags;
  logic [CntBits-1:0] count;
  logic [TaskIdBits-1:0] w_task [WaitDepth];
  logic [31:0]           w_mask [WaitDepth];
  logic [1:0]            w_mode [WaitDepth];
  logic [PrioBits-1:0]   w_prio [WaitDepth];

  // latched request
  logic                  r_type;
  logic [31:0]           r_mask;
  logic [1:0]            r_opt;
  logic [TaskIdBits-1:0] r_tid;
  logic [PrioBits-1:0]   r_prio;

  // scan state
  logic [CntBits-1:0]  idx;
  logic [IdxBits-1:0]  best;
  logic [PrioBits-1:0] best_prio;
  logic                found;
  status_t             res_status;
  logic [TaskIdBits-1:0] res_woken;

  logic [IdxBits-1:0] idx_s;
  logic cur_match, pend_match, cur_take;
  assign idx_s = idx[IdxBits-1:0];
  assign cur_match = (idx < count) && flags_match(flags, w_mask[idx_s], w_mode[idx_s]);
  assign pend_match = flags_match(flags, r_mask, r_opt);
  // current entry beats the best so far (ties keep the earlier one)
  assign cur_take = cur_match && (!found || w_prio[idx_s] < best_prio);

  assign stat.is_pend = (r_type == REQ_PEND);
  assign stat.scan_last = (idx >= CntBits'(WaitDepth - 1)) || (idx + 1'b1 >= count);
  assign stat.found = found || cur_match;
  assign stat.shift_last = ({1'b0, idx} + 1'b1 >= {1'b0, count});

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r_type <= req_type;
      r_mask <= bit_mask;
      r_opt <= option;
      r_tid <= task_id;
      r_prio <= task_priority;
    end
  end

  // flag word and table
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      count <= '0;
    end else if (cfg_valid) begin
      flags <= cfg_data;
      count <= '0;
    end else if (cmd.apply) begin
      if (r_type == REQ_POST) begin
        flags <= (r_opt == 2'd0) ? (flags | r_mask) : (flags & ~r_mask);
      end else if (pend_match) begin
        if (!r_opt[1]) flags <= flags & ~r_mask;
      end else if (count < CntBits'(WaitDepth)) begin
        count <= count + 1'b1;
      end
    end else if (cmd.wake) begin
      if (!w_mode[best][1]) flags <= flags & ~w_mask[best];
      if (stat.shift_last) count <= count - 1'b1;
    end else if (cmd.shift_step && stat.shift_last) begin
      count <= count - 1'b1;
    end
  end

  // table writes: append on queue, shift down on removal
  always_ff @(posedge clk) begin
    if (cmd.apply && r_type == REQ_PEND && !pend_match && count < CntBits'(WaitDepth)) begin
      w_task[count[IdxBits-1:0]] <= r_tid;
      w_mask[count[IdxBits-1:0]] <= r_mask;
      w_mode[count[IdxBits-1:0]] <= r_opt;
      w_prio[count[IdxBits-1:0]] <= r_prio;
    end else if ((cmd.wake || cmd.shift_step) && !stat.shift_last) begin
      w_task[idx_s] <= w_task[idx_s + 1'b1];
      w_mask[idx_s] <= w_mask[idx_s + 1'b1];
      w_mode[idx_s] <= w_mode[idx_s + 1'b1];
      w_prio[idx_s] <= w_prio[idx_s + 1'b1];
    end
  end

  // scan and shift index, best tracking, result
  // the last scan step leaves idx on the winner so the wake cycle starts the shift there
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      idx <= '0;
      found <= 1'b0;
      res_woken <= '0;
      if (r_type == REQ_POST) res_status <= ST_POST_IDLE;
      else if (pend_match) res_status <= ST_PEND_GRANT;
      else if (count < CntBits'(WaitDepth)) res_status <= ST_PEND_QUEUED;
      else res_status <= ST_PEND_FULL;
    end else if (cmd.scan_step) begin
      if (cur_take) begin
        best <= idx_s;
        best_prio <= w_prio[idx_s];
        found <= 1'b1;
      end
      if (stat.scan_last) idx <= cur_take ? idx : {1'b0, best};
      else idx <= idx + 1'b1;
    end else if (cmd.wake) begin
      res_status <= ST_POST_WOKE;
      res_woken <= w_task[best];
      idx <= {1'b0, best} + 1'b1;
    end else if (cmd.shift_step) begin
      idx <= idx + 1'b1;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.done;
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status <= res_status;
      woken_task <= res_woken;
      flags_after <= flags;
    end
  end

endmodule

// ===== rtl/efg_checker.sv =====
`include "event_flag_group_wait_wake_core_defines.svh"

module efg_checker
  import efg_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status,
  input logic [4:0] woken_task
);

  // an accepted request makes the block busy
  `EFG_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "start not taken")
  // a result shows only while idle
  `EFG_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "busy during result")
  // status code in range
  `EFG_ASSERT_IMPL(a_status_rng, clk, rst, done, status <= ST_PEND_FULL, "bad status")
  // woken task is zero unless a wake
  `EFG_ASSERT_IMPL(a_woken_zero, clk, rst, done && status != ST_POST_WOKE,
    woken_task == '0, "stray woken task")

endmodule

bind event_flag_group_wait_wake_core efg_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .woken_task(woken_task)
);
